/* sv/sha1_pkg.sv */
// Package for the SHA-1 byte stream hasher.
// Holds constants, shared types, the round helper functions and a hex digit helper.
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned QDEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD0,
        ST_PADE,
        ST_PADZ,
        ST_LEN,
        ST_ERR,
        ST_OUT
    } back_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'd0, nib};
        else
            return 8'h37 + {4'd0, nib};
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20)
            return (b & c) | (~b & d);
        else if (r < 7'd40 || r >= 7'd60)
            return b ^ c ^ d;
        else
            return (b & c) | (b & d) | (c & d);
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20)
            return K0;
        else if (r < 7'd40)
            return K1;
        else if (r < 7'd60)
            return K2;
        else
            return K3;
    endfunction

endpackage

/* sv/sha1_if.sv */
// Valid/ready channel interfaces for the hasher.
// Depends on sha1_pkg for the payload types.
interface sha1_in_if;
    logic                valid;
    logic                ready;
    sha1_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha1_out_if;
    logic                valid;
    logic                ready;
    sha1_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha1_cfg_if;
    logic valid;
    logic ready;
    logic hex_output;
    modport source (output valid, output hex_output, input ready);
    modport sink (input valid, input hex_output, output ready);
endinterface

/* sv/sha1_byte_stream_hasher_core.sv */
// SHA-1 byte stream hasher top level. Input transfers pass a 4-entry queue and the back part
// absorbs one byte per cycle while idle; each full 64-byte block is then compressed, and no
// byte is taken meanwhile. A closing item adds padding, one or two compressions
// and 20 raw or 40 hex result bytes; the input stalls while the queue
// is full. Reset (rst_n low, asynchronous) restores the initial chain, clears counts and
// sets hex mode; the schedule window needs no clearing.
module sha1_byte_stream_hasher_core (
    input logic        clk,
    input logic        rst_n,
    sha1_in_if.sink    in_ch,
    sha1_out_if.source out_ch,
    sha1_cfg_if.sink   cfg
);
    import sha1_pkg::*;

    logic     hex_reg;
    logic     q_pop;
    logic     q_valid;
    in_item_t q_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hex_reg <= 1'b1;
        else if (cfg.valid)
            hex_reg <= cfg.hex_output;
    end

    sha1_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_ch.payload),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    sha1_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .hex_mode  (hex_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.payload)
    );
endmodule

/* sv/sha1_fifo.sv */
// Short item queue between the front and back parts.
// Depends on sha1_pkg.
module sha1_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sha1_pkg::in_item_t push_item,
    output logic               full,
    input  logic               pop,
    output sha1_pkg::in_item_t pop_item,
    output logic               not_empty
);
    import sha1_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    in_item_t       mem_reg [QDEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

/* sv/sha1_front.sv */
// Front part: accepts input transfers and drops empty items.
// Depends on sha1_pkg and sha1_fifo.
module sha1_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha1_pkg::in_item_t in_item,
    input  logic               pop,
    output sha1_pkg::in_item_t pop_item,
    output logic               not_empty
);
    import sha1_pkg::*;

    logic full;
    logic push;

    assign in_ready = !full;
    assign push     = in_valid && !full && (in_item.byte_valid || in_item.is_last);

    sha1_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );
endmodule

/* sv/sha1_back.sv */
// Back part: buffers bytes, pads, runs the 80 rounds and emits the digest or an error item.
// Depends on sha1_pkg.
module sha1_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hex_mode,
    input  logic                q_valid,
    input  sha1_pkg::in_item_t  q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output sha1_pkg::out_item_t out_item
);
    import sha1_pkg::*;

    back_state_t state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;
    logic        more_reg, more_next;
    logic        zpad_reg, zpad_next;
    logic [5:0]  ocnt_reg, ocnt_next;
    logic        hex_reg, hex_next;
    logic        ov_reg, ov_next;
    out_item_t   oi_reg, oi_next;

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        start;
    logic        done;
    logic [31:0] wnew, wcur, tval;
    logic [63:0] len_add;
    logic [4:0]  dig_idx;
    logic [7:0]  dig_byte;
    logic [5:0]  ocnt_last;
    logic        out_free;

    assign len_add = len_reg + 64'd8;
    assign out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_item = oi_reg;

    assign wnew = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                   w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign wcur = (rnd_reg < 7'd16) ? w_reg[0] : wnew;
    assign tval = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                + e_reg + wcur + round_k(rnd_reg);
    assign done = (rnd_reg == 7'd79);

    assign dig_idx   = hex_reg ? ocnt_reg[5:1] : ocnt_reg[4:0];
    assign dig_byte  = 8'(h_reg[dig_idx[4:2]] >> (5'd24 - {dig_idx[1:0], 3'b000}));
    assign ocnt_last = hex_reg ? 6'd39 : 6'd19;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        more_next  = more_reg;
        zpad_next  = zpad_reg;
        ocnt_next  = ocnt_reg;
        hex_next   = hex_reg;
        ov_next    = ov_reg && !out_ready;
        oi_next    = oi_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = fill_reg;
        wr_data    = q_item.data_byte;
        start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.byte_valid && !ovf_reg)
                    begin
                        len_next = len_add;
                        if (len_add == '0)
                            ovf_next = 1'b1;
                        else
                        begin
                            wr_en = 1'b1;
                            fill_next = fill_reg + 6'd1;
                            if (fill_reg == 6'd63)
                            begin
                                start = 1'b1;
                                fin_next = 1'b0;
                                zpad_next = 1'b0;
                                more_next = q_item.is_last;
                                state_next = ST_COMP;
                            end
                        end
                    end
                    if (q_item.is_last && state_next == ST_IDLE)
                    begin
                        if (ovf_next)
                            state_next = ST_ERR;
                        else
                            state_next = ST_PAD0;
                    end
                end
            end
            ST_COMP:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (done)
                begin
                    rnd_next = '0;
                    if (fin_reg)
                    begin
                        ocnt_next = '0;
                        hex_next = hex_mode;
                        state_next = ST_OUT;
                    end
                    else if (more_reg)
                        state_next = ST_PAD0;
                    else if (zpad_reg)
                        state_next = ST_PADZ;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_PAD0:
            begin
                wr_en = 1'b1;
                wr_data = PAD_BYTE;
                fill_next = fill_reg + 6'd1;
                more_next = 1'b0;
                if (fill_reg == 6'd63)
                begin
                    start = 1'b1;
                    fin_next = 1'b0;
                    zpad_next = 1'b1;
                    state_next = ST_COMP;
                end
                else if (fill_reg >= 6'd56)
                    state_next = ST_PADE;
                else
                    state_next = ST_PADZ;
            end
            ST_PADE:
            begin
                wr_en = 1'b1;
                wr_data = 8'h00;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    start = 1'b1;
                    fin_next = 1'b0;
                    zpad_next = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_PADZ:
            begin
                zpad_next = 1'b0;
                if (fill_reg == 6'd56)
                    state_next = ST_LEN;
                else
                begin
                    wr_en = 1'b1;
                    wr_data = 8'h00;
                    fill_next = fill_reg + 6'd1;
                end
            end
            ST_LEN:
            begin
                wr_en = 1'b1;
                wr_data = 8'(len_reg >> (6'd56 - {fill_reg[2:0], 3'b000}));
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    start = 1'b1;
                    fin_next = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oi_next = '{out_byte: 8'h00, status: 1'b1, last: 1'b1};
                    fill_next = '0;
                    len_next = '0;
                    ovf_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oi_next.status = 1'b0;
                    oi_next.last = (ocnt_reg == ocnt_last);
                    if (!hex_reg)
                        oi_next.out_byte = dig_byte;
                    else if (!ocnt_reg[0])
                        oi_next.out_byte = hex_char(dig_byte[7:4]);
                    else
                        oi_next.out_byte = hex_char(dig_byte[3:0]);
                    ocnt_next = ocnt_reg + 6'd1;
                    if (ocnt_reg == ocnt_last)
                    begin
                        fill_next = '0;
                        len_next = '0;
                        ovf_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        oi_reg <= oi_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMP)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wcur;
            a_reg <= tval;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            if (wr_en)
                w_reg[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
            if (start)
            begin
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
                e_reg <= h_reg[4];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg[0] <= H0;
            h_reg[1] <= H1;
            h_reg[2] <= H2;
            h_reg[3] <= H3;
            h_reg[4] <= H4;
            fill_reg <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            rnd_reg  <= '0;
            fin_reg  <= 1'b0;
            more_reg <= 1'b0;
            zpad_reg <= 1'b0;
            ocnt_reg <= '0;
            hex_reg  <= 1'b1;
            ov_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            more_reg  <= more_next;
            zpad_reg  <= zpad_next;
            ocnt_reg  <= ocnt_next;
            hex_reg   <= hex_next;
            ov_reg    <= ov_next;
            if (state_reg == ST_COMP && done)
            begin
                h_reg[0] <= h_reg[0] + tval;
                h_reg[1] <= h_reg[1] + a_reg;
                h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                h_reg[3] <= h_reg[3] + c_reg;
                h_reg[4] <= h_reg[4] + d_reg;
            end
            else if (state_next == ST_IDLE && (state_reg == ST_OUT || state_reg == ST_ERR))
            begin
                h_reg[0] <= H0;
                h_reg[1] <= H1;
                h_reg[2] <= H2;
                h_reg[3] <= H3;
                h_reg[4] <= H4;
            end
        end
    end
endmodule
